@@ rtl/dcwa_pkg.sv @@
// Package with the types and constants shared by the digital clock with alarm files.
package dcwa_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_MODE = 2'd1,
        FUNC_INC  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        MODE_NORMAL      = 2'd0,
        MODE_SET_HOURS   = 2'd1,
        MODE_SET_MINUTES = 2'd2,
        MODE_SET_ALARM   = 2'd3
    } mode_t;

    typedef enum logic {
        CFG_DEBOUNCE     = 1'b0,
        CFG_ALARM_MINUTE = 1'b1
    } cfg_index_t;

    localparam int CFG_DATA_W = 16;

    localparam logic [4:0]  HOUR_LAST      = 5'd23;
    localparam logic [5:0]  MINUTE_LAST    = 6'd59;
    localparam logic [5:0]  SECOND_LAST    = 6'd59;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd300;

    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] press_time;
    } event_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [1:0] mode;
        logic       seconds_led;
        logic       setting_led;
        logic       alarm_match;
        logic       press_accepted;
    } result_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic advance;
    } flow_t;

endpackage

@@ rtl/dcwa_in_stage.sv @@
// Input register that captures one event word from the slave-side stream.
module dcwa_in_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 advance,
    output logic                 in_valid,
    output dcwa_pkg::event_t     ev
);

    logic             in_valid_reg;
    logic             in_valid_next;
    dcwa_pkg::event_t ev_reg;

    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ev_reg.func       <= s_tuser;
            ev_reg.press_time <= s_tdata;
        end
    end

    assign in_valid = in_valid_reg;
    assign ev       = ev_reg;

endmodule

@@ rtl/dcwa_core.sv @@
// Clock, mode and alarm state with the single-pass update for one event.
module dcwa_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [dcwa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            advance,
    input  dcwa_pkg::event_t                ev,
    output dcwa_pkg::result_t               result
);

    logic [4:0]      hour_reg;
    logic [4:0]      hour_next;
    logic [5:0]      minute_reg;
    logic [5:0]      minute_next;
    logic [5:0]      second_reg;
    logic [5:0]      second_next;
    dcwa_pkg::mode_t mode_reg;
    dcwa_pkg::mode_t mode_next;
    dcwa_pkg::mode_t mode_step;
    logic [4:0]      alarm_hour_reg;
    logic [4:0]      alarm_hour_next;
    logic [31:0]     last_press_reg;
    logic [31:0]     last_press_next;
    logic [15:0]     debounce_reg;
    logic [5:0]      alarm_minute_reg;

    logic [31:0]     gap;
    logic            is_press;
    logic            accepted;
    logic [4:0]      hour_inc;
    logic [5:0]      minute_inc;
    logic [4:0]      alarm_inc;

    assign gap      = ev.press_time - last_press_reg;
    assign is_press = (ev.func == dcwa_pkg::FUNC_MODE) || (ev.func == dcwa_pkg::FUNC_INC);
    assign accepted = is_press && (gap >= {16'd0, debounce_reg});

    assign hour_inc   = (hour_reg == dcwa_pkg::HOUR_LAST) ? 5'd0 : hour_reg + 5'd1;
    assign minute_inc = (minute_reg == dcwa_pkg::MINUTE_LAST) ? 6'd0 : minute_reg + 6'd1;
    assign alarm_inc  = (alarm_hour_reg == dcwa_pkg::HOUR_LAST) ? 5'd0
                      : alarm_hour_reg + 5'd1;

    always_comb
    begin
        unique case (mode_reg)
            dcwa_pkg::MODE_NORMAL:      mode_step = dcwa_pkg::MODE_SET_HOURS;
            dcwa_pkg::MODE_SET_HOURS:   mode_step = dcwa_pkg::MODE_SET_MINUTES;
            dcwa_pkg::MODE_SET_MINUTES: mode_step = dcwa_pkg::MODE_SET_ALARM;
            dcwa_pkg::MODE_SET_ALARM:   mode_step = dcwa_pkg::MODE_NORMAL;
            default:                    mode_step = dcwa_pkg::MODE_NORMAL;
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg;
        if (accepted && (ev.func == dcwa_pkg::FUNC_MODE))
        begin
            mode_next = mode_step;
        end
    end

    always_comb
    begin
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;
        alarm_hour_next = alarm_hour_reg;
        last_press_next = last_press_reg;
        if (accepted)
        begin
            last_press_next = ev.press_time;
        end
        unique case (ev.func)
            dcwa_pkg::FUNC_TICK:
            begin
                if (mode_reg == dcwa_pkg::MODE_NORMAL)
                begin
                    if (second_reg == dcwa_pkg::SECOND_LAST)
                    begin
                        second_next = 6'd0;
                        minute_next = minute_inc;
                        if (minute_reg == dcwa_pkg::MINUTE_LAST)
                        begin
                            hour_next = hour_inc;
                        end
                    end
                    else
                    begin
                        second_next = second_reg + 6'd1;
                    end
                end
            end
            dcwa_pkg::FUNC_INC:
            begin
                if (accepted)
                begin
                    if (mode_reg == dcwa_pkg::MODE_SET_HOURS)
                    begin
                        hour_next = hour_inc;
                    end
                    else if (mode_reg == dcwa_pkg::MODE_SET_MINUTES)
                    begin
                        minute_next = minute_inc;
                    end
                    else if (mode_reg == dcwa_pkg::MODE_SET_ALARM)
                    begin
                        alarm_hour_next = alarm_inc;
                    end
                end
            end
            default:
            begin
                hour_next = hour_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg       <= 5'd0;
            minute_reg     <= 6'd0;
            second_reg     <= 6'd0;
            mode_reg       <= dcwa_pkg::MODE_NORMAL;
            alarm_hour_reg <= 5'd0;
            last_press_reg <= 32'd0;
        end
        else if (advance)
        begin
            hour_reg       <= hour_next;
            minute_reg     <= minute_next;
            second_reg     <= second_next;
            mode_reg       <= mode_next;
            alarm_hour_reg <= alarm_hour_next;
            last_press_reg <= last_press_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= dcwa_pkg::DEBOUNCE_RESET;
            alarm_minute_reg <= 6'd0;
        end
        else if (cfg_we)
        begin
            unique case (dcwa_pkg::cfg_index_t'(cfg_index))
                dcwa_pkg::CFG_DEBOUNCE:     debounce_reg     <= cfg_data;
                dcwa_pkg::CFG_ALARM_MINUTE: alarm_minute_reg <= cfg_data[5:0];
                default:                    debounce_reg     <= debounce_reg;
            endcase
        end
    end

    always_comb
    begin
        result.hours          = hour_next;
        result.minutes        = minute_next;
        result.seconds        = second_next;
        result.mode           = mode_next;
        result.seconds_led    = second_next[0];
        result.setting_led    = (mode_next != dcwa_pkg::MODE_NORMAL);
        result.alarm_match    = (hour_next == alarm_hour_next)
                             && (minute_next == alarm_minute_reg);
        result.press_accepted = accepted;
    end

endmodule

@@ rtl/dcwa_out_stage.sv @@
// Result register that holds one result word for the master-side stream.
module dcwa_out_stage
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  dcwa_pkg::result_t                 result,
    output logic                              out_free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dcwa_pkg::OUT_DATA_W-1:0]   m_tdata
);

    logic              out_valid_reg;
    logic              out_valid_next;
    dcwa_pkg::result_t result_reg;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       result_reg.press_accepted,
                       result_reg.alarm_match,
                       result_reg.setting_led,
                       result_reg.seconds_led,
                       result_reg.mode,
                       result_reg.seconds,
                       result_reg.minutes,
                       result_reg.hours};

endmodule

@@ rtl/digital_clock_with_alarm_setting_top.sv @@
// Top level of the digital clock with alarm hour setting.
// Each event word is registered on entry, processed combinationally against the clock, mode and
// alarm state, and its result word is registered on exit, so an event passes the input register
// and its result then the output register, and one event per cycle is sustained while the master side
// keeps m_tready high; the combinational state update in the core sets that rate. Configuration
// writes take effect on the next edge and are meant to be made while the block is idle.
module digital_clock_with_alarm_setting_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [dcwa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0 up: press_time[31:0].
    input  logic [31:0]                     s_tdata,
    // Fields from bit 0 up: func[1:0].
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0 up: hours[4:0], minutes[10:5], seconds[16:11], mode[18:17],
    // seconds_led[19], setting_led[20], alarm_match[21], press_accepted[22], zero[23].
    output logic [dcwa_pkg::OUT_DATA_W-1:0] m_tdata
);

    dcwa_pkg::flow_t   flow;
    dcwa_pkg::event_t  ev;
    dcwa_pkg::result_t result;

    assign flow.advance = flow.in_valid && flow.out_free;

    dcwa_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (flow.advance),
        .in_valid (flow.in_valid),
        .ev       (ev)
    );

    dcwa_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (flow.advance),
        .ev        (ev),
        .result    (result)
    );

    dcwa_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (flow.advance),
        .result   (result),
        .out_free (flow.out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ rtl/dcwa_checker.sv @@
// Port-level checker for the digital clock top level and the bind that attaches it.
module dcwa_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [dcwa_pkg::OUT_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("Stalled result word changed or was dropped.");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[4:0] <= 5'd23) && (m_tdata[10:5] <= 6'd59)
                      && (m_tdata[16:11] <= 6'd59)))
        else $error("Clock field out of range.");

    a_seconds_led: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[19] == m_tdata[11]))
        else $error("Seconds LED does not follow the seconds count.");

    a_setting_led: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[20] == (m_tdata[18:17] != 2'd0)))
        else $error("Setting LED does not follow the mode.");

endmodule

bind digital_clock_with_alarm_setting_top dcwa_checker u_dcwa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ dv/tb_digital_clock_with_alarm_setting_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the digital clock with alarm: directed and random event words against a predictor.

class clock_readout_board;
    logic [4:0]          hrs;
    logic [5:0]          mins;
    logic [5:0]          secs;
    dcwa_pkg::mode_t     mode;
    logic [4:0]          alarm_hr;
    logic [31:0]         last_press;
    logic [15:0]         debounce;
    logic [5:0]          alarm_min;
    dcwa_pkg::result_t   expected_readouts[$];
    int                  errors;

    function new();
        hrs        = '0;
        mins       = '0;
        secs       = '0;
        mode       = dcwa_pkg::MODE_NORMAL;
        alarm_hr   = '0;
        last_press = '0;
        debounce   = dcwa_pkg::DEBOUNCE_RESET;
        alarm_min  = '0;
        errors     = 0;
    endfunction

    function void set_register(dcwa_pkg::cfg_index_t idx, logic [15:0] value);
        if (idx == dcwa_pkg::CFG_DEBOUNCE)
        begin
            debounce = value;
        end
        else
        begin
            alarm_min = value[5:0];
        end
    endfunction

    function int pending();
        return expected_readouts.size();
    endfunction

    // Returns one when the word moved the clock or was a press that got through.
    function bit note_event(logic [1:0] func, logic [31:0] press_time);
        logic [31:0]       gap;
        bit                accepted;
        bit                moved;
        dcwa_pkg::result_t r;
        accepted = 1'b0;
        moved    = 1'b0;
        if (func == dcwa_pkg::FUNC_TICK)
        begin
            if (mode == dcwa_pkg::MODE_NORMAL)
            begin
                moved = 1'b1;
                if (secs == dcwa_pkg::SECOND_LAST)
                begin
                    secs = '0;
                    if (mins == dcwa_pkg::MINUTE_LAST)
                    begin
                        mins = '0;
                        hrs  = (hrs == dcwa_pkg::HOUR_LAST) ? 5'd0 : hrs + 5'd1;
                    end
                    else
                    begin
                        mins = mins + 6'd1;
                    end
                end
                else
                begin
                    secs = secs + 6'd1;
                end
            end
        end
        else if (func == dcwa_pkg::FUNC_MODE || func == dcwa_pkg::FUNC_INC)
        begin
            gap = press_time - last_press;
            if (gap >= {16'd0, debounce})
            begin
                accepted   = 1'b1;
                last_press = press_time;
                if (func == dcwa_pkg::FUNC_MODE)
                begin
                    mode = dcwa_pkg::mode_t'(mode + 2'd1);
                end
                else
                begin
                    case (mode)
                        dcwa_pkg::MODE_SET_HOURS:
                            hrs = (hrs == dcwa_pkg::HOUR_LAST) ? 5'd0 : hrs + 5'd1;
                        dcwa_pkg::MODE_SET_MINUTES:
                            mins = (mins == dcwa_pkg::MINUTE_LAST) ? 6'd0 : mins + 6'd1;
                        dcwa_pkg::MODE_SET_ALARM:
                            alarm_hr = (alarm_hr == dcwa_pkg::HOUR_LAST) ? 5'd0
                                     : alarm_hr + 5'd1;
                        default: ;
                    endcase
                end
            end
        end
        r.hours          = hrs;
        r.minutes        = mins;
        r.seconds        = secs;
        r.mode           = mode;
        r.seconds_led    = secs[0];
        r.setting_led    = (mode != dcwa_pkg::MODE_NORMAL);
        r.alarm_match    = (hrs == alarm_hr) && (mins == alarm_min);
        r.press_accepted = accepted;
        expected_readouts.push_back(r);
        return moved | accepted;
    endfunction

    task flag_mismatch(string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    task compare_field(string name, int got, int want);
        if (got != want)
        begin
            flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    task check_readout(logic [dcwa_pkg::OUT_DATA_W-1:0] d);
        dcwa_pkg::result_t want;
        if (expected_readouts.size() == 0)
        begin
            flag_mismatch($sformatf("readout word %h arrived with nothing expected", d));
            return;
        end
        want = expected_readouts.pop_front();
        compare_field("hours", d[4:0], want.hours);
        compare_field("minutes", d[10:5], want.minutes);
        compare_field("seconds", d[16:11], want.seconds);
        compare_field("mode", d[18:17], want.mode);
        compare_field("seconds_led", d[19], want.seconds_led);
        compare_field("setting_led", d[20], want.setting_led);
        compare_field("alarm_match", d[21], want.alarm_match);
        compare_field("press_accepted", d[22], want.press_accepted);
        compare_field("pad bit", d[23], 0);
    endtask
endclass

module tb_digital_clock_with_alarm_setting_top;

    localparam logic [1:0] FUNC_NONE = 2'd3;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic                            cfg_index = 1'b0;
    logic [dcwa_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [31:0]                     s_tdata   = '0;
    logic [1:0]                      s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [dcwa_pkg::OUT_DATA_W-1:0] m_tdata;

    bit                              tx_gaps   = 1'b1;
    bit                              rx_stalls = 1'b1;
    clock_readout_board              board;

    digital_clock_with_alarm_setting_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_word(input logic [1:0] func, input logic [31:0] press_time,
                             output bit took);
        if (tx_gaps && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= press_time;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        took = board.note_event(func, press_time);
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_settings(input logic [15:0] debounce, input logic [15:0] alarm_minute);
        cfg_we    <= 1'b1;
        cfg_index <= dcwa_pkg::CFG_DEBOUNCE;
        cfg_data  <= debounce;
        @(posedge clk);
        cfg_index <= dcwa_pkg::CFG_ALARM_MINUTE;
        cfg_data  <= alarm_minute;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_register(dcwa_pkg::CFG_DEBOUNCE, debounce);
        board.set_register(dcwa_pkg::CFG_ALARM_MINUTE, alarm_minute);
    endtask

    // Mostly clears the debounce window, sometimes lands on its edge or one short of it.
    function automatic logic [31:0] later_stamp();
        logic [31:0] window;
        window = {16'd0, board.debounce};
        if ($urandom_range(0, 11) == 0)
        begin
            return board.last_press + window - 32'd1;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            return board.last_press + window;
        end
        return board.last_press + window + $urandom_range(1, 500);
    endfunction

    task automatic run_random(input int goal);
        int          done;
        int          kind;
        int          steps;
        int          target;
        bit          took;
        logic [31:0] offset;
        done = 0;
        while (done < goal)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 8)
            begin
                repeat ($urandom_range(1, 70))
                begin
                    send_word(dcwa_pkg::FUNC_TICK, $urandom(), took);
                    done++;
                end
            end
            else if (kind < 14)
            begin
                // Walk to a setting mode, bump its field, then walk back to normal.
                target = $urandom_range(1, 3);
                while (board.mode != dcwa_pkg::mode_t'(target))
                begin
                    send_word(dcwa_pkg::FUNC_MODE, later_stamp(), took);
                    done++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    case (dcwa_pkg::mode_t'(target))
                        dcwa_pkg::MODE_SET_HOURS:
                            steps = int'(dcwa_pkg::HOUR_LAST) - int'(board.hrs);
                        dcwa_pkg::MODE_SET_MINUTES:
                            steps = int'(dcwa_pkg::MINUTE_LAST) - int'(board.mins);
                        default:
                            steps = int'(dcwa_pkg::HOUR_LAST) - int'(board.alarm_hr);
                    endcase
                    if (steps == 0)
                    begin
                        steps = 1;
                    end
                end
                else
                begin
                    steps = $urandom_range(1, 30);
                end
                while (steps > 0)
                begin
                    send_word(dcwa_pkg::FUNC_INC, later_stamp(), took);
                    done++;
                    if (took)
                    begin
                        steps--;
                    end
                end
                while (board.mode != dcwa_pkg::MODE_NORMAL)
                begin
                    send_word(dcwa_pkg::FUNC_MODE, later_stamp(), took);
                    done++;
                end
            end
            else if (kind < 17)
            begin
                repeat (4)
                begin
                    case ($urandom_range(0, 4))
                        0:       offset = 32'd0;
                        1:       offset = {16'd0, board.debounce} - 32'd1;
                        2:       offset = {16'd0, board.debounce};
                        3:       offset = {16'd0, board.debounce} + 32'd1;
                        default: offset = $urandom();
                    endcase
                    send_word(2'($urandom_range(1, 2)), board.last_press + offset, took);
                    done++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_word(2'($urandom_range(0, 3)), $urandom(), took);
                    done++;
                end
            end
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                board.check_readout(m_tdata);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (rx_stalls && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        bit took;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 300 tick debounce, alarm at 00:00.
        send_word(dcwa_pkg::FUNC_TICK, 32'hFFFF_FFFF, took);
        send_word(FUNC_NONE, 32'h1234_5678, took);
        send_word(dcwa_pkg::FUNC_MODE, 32'd0, took);
        send_word(dcwa_pkg::FUNC_INC, 32'd299, took);
        send_word(dcwa_pkg::FUNC_MODE, 32'd300, took);
        send_word(dcwa_pkg::FUNC_TICK, 32'd0, took);
        send_word(dcwa_pkg::FUNC_INC, 32'd599, took);
        send_word(dcwa_pkg::FUNC_INC, 32'd600, took);
        send_word(dcwa_pkg::FUNC_MODE, 32'hFFFF_FFFF, took);
        send_word(dcwa_pkg::FUNC_INC, 32'd299, took);
        send_word(FUNC_NONE, 32'd0, took);
        send_word(dcwa_pkg::FUNC_MODE, 32'h8000_0000, took);
        send_word(dcwa_pkg::FUNC_INC, 32'h8000_012C, took);
        send_word(dcwa_pkg::FUNC_MODE, 32'h8000_0258, took);
        send_word(dcwa_pkg::FUNC_INC, 32'h8000_0384, took);
        send_word(dcwa_pkg::FUNC_TICK, 32'd0, took);
        drain_and_settle();

        write_settings(16'd0, 16'd59);
        run_random(100);
        drain_and_settle();

        tx_gaps = 1'b0;
        write_settings(16'hFFFF, 16'hFFFF);
        run_random(80);
        drain_and_settle();

        tx_gaps   = 1'b1;
        rx_stalls = 1'b0;
        write_settings(16'd1, 16'($urandom_range(0, 59)));
        run_random(110);
        drain_and_settle();

        rx_stalls = 1'b1;
        write_settings(16'($urandom_range(2, 2000)), 16'($urandom()));
        run_random(110);
        drain_and_settle();

        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        write_settings(dcwa_pkg::DEBOUNCE_RESET, 16'd0);
        run_random(120);
        drain_and_settle();

        repeat (8) @(posedge clk);
        if (board.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/dcwa_pkg.sv
rtl/dcwa_in_stage.sv
rtl/dcwa_core.sv
rtl/dcwa_out_stage.sv
rtl/digital_clock_with_alarm_setting_top.sv
rtl/dcwa_checker.sv
dv/tb_digital_clock_with_alarm_setting_top.sv
